FILE: src/bdq_pkg.sv
// shared types and constants for the byte deque
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int DATA_W    = 8;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int OCC_W     = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_POP_EMPTY = 2'd1,
        STAT_PUSH_FULL = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] popped_byte;
        status_t           status;
        logic [DATA_W-1:0] front_byte;
        logic [DATA_W-1:0] back_byte;
        logic [OCC_W-1:0]  occupancy;
        logic              empty_flag;
        logic              full_flag;
    } result_t;

endpackage

`default_nettype wire

FILE: src/byte_deque_top.sv
// top level of the byte deque: stream ports, ring storage and result register
//
// channel  dir  transaction carries
// s_       in   tuser: req_type[1:0]; tdata: push_byte[7:0]
// m_       out  tuser: status[1:0]; tdata: popped, front, back, occupancy, empty, full
//
// a push, or a pop that empties the deque or fails, completes at once: a request can
// be accepted every clock while idle and the result register has room. a pop that
// leaves bytes behind waits in S_READ on the registered ram read of the new end byte.
// reset clears the ring pointer and the count; the ram needs no clearing.
// a held result does not block the next request as long as m_tready takes it.
`default_nettype none

module byte_deque_top #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // push_byte[7:0]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // popped_byte[7:0], front_byte[15:8],
                                        // back_byte[23:16], occupancy[31:24],
                                        // empty_flag[32], full_flag[33], zero above
    output logic [1:0]       m_tuser    // status[1:0]
);

    import bdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic               in_fire;
    logic               out_room;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;
    logic               res_valid;
    result_t            res;
    logic               m_tvalid_reg;
    result_t            res_reg;

    assign in_fire  = s_tvalid && s_tready;
    assign out_room = !m_tvalid_reg || m_tready;

    bdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .req       (req_t'(s_tuser)),
        .push_byte (s_tdata),
        .out_room  (out_room),
        .in_ready  (s_tready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res)
    );

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {6'b0, res_reg.full_flag, res_reg.empty_flag, res_reg.occupancy,
                       res_reg.back_byte, res_reg.front_byte, res_reg.popped_byte};

endmodule

`default_nettype wire

FILE: src/bdq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/bdq_ctrl.sv
// ring pointers, end-byte cache and request sequencer of the byte deque
`default_nettype none

module bdq_ctrl #(
    parameter int DEPTH = 128
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_fire,
    input  wire bdq_pkg::req_t                req,
    input  wire logic [bdq_pkg::DATA_W-1:0]   push_byte,
    input  wire logic                         out_room,
    output logic                              in_ready,
    output logic                              ram_we,
    output logic [$clog2(DEPTH)-1:0]          ram_waddr,
    output logic [bdq_pkg::DATA_W-1:0]        ram_wdata,
    output logic                              ram_re,
    output logic [$clog2(DEPTH)-1:0]          ram_raddr,
    input  wire logic [bdq_pkg::DATA_W-1:0]   ram_rdata,
    output logic                              res_valid,
    output bdq_pkg::result_t                  res
);

    import bdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DATA_W-1:0]   front_val_reg, front_val_next;
    logic [DATA_W-1:0]   back_val_reg, back_val_next;
    logic [DATA_W-1:0]   popped_reg, popped_next;
    logic                side_front_reg, side_front_next;
    logic [DATA_W-1:0]   popped;
    status_t             status;
    logic                none_held;
    logic                is_full;
    logic [CNT_W-1:0]    count_m2;

    // (base + off) mod DEPTH, both operands below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
    endfunction

    assign none_held = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign count_m2  = count_reg - CNT_W'(2);
    assign in_ready  = (state_reg == S_IDLE) && out_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
        front_val_reg  <= front_val_next;
        back_val_reg   <= back_val_next;
        popped_reg     <= popped_next;
        side_front_reg <= side_front_next;
    end

    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        front_val_next  = front_val_reg;
        back_val_next   = back_val_reg;
        popped_next     = popped_reg;
        side_front_next = side_front_reg;
        ram_we          = 1'b0;
        ram_waddr       = front_reg;
        ram_wdata       = push_byte;
        ram_re          = 1'b0;
        ram_raddr       = front_reg;
        res_valid       = 1'b0;
        popped          = '0;
        status          = STAT_DONE;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (req)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            res_valid = 1'b1;
                            if (is_full) begin
                                status = STAT_PUSH_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                if (req == REQ_PUSH_FRONT) begin
                                    front_next     = ring_dec(front_reg);
                                    ram_waddr      = ring_dec(front_reg);
                                    front_val_next = push_byte;
                                    if (none_held) begin
                                        back_val_next = push_byte;
                                    end
                                end else begin
                                    ram_waddr     = ring_add(front_reg, count_reg[IDX_W-1:0]);
                                    back_val_next = push_byte;
                                    if (none_held) begin
                                        front_val_next = push_byte;
                                    end
                                end
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            if (none_held) begin
                                res_valid = 1'b1;
                                status    = STAT_POP_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                                popped     = (req == REQ_POP_FRONT) ? front_val_reg
                                                                    : back_val_reg;
                                if (req == REQ_POP_FRONT) begin
                                    front_next = ring_inc(front_reg);
                                end
                                if (count_reg == CNT_W'(1)) begin
                                    res_valid = 1'b1;
                                end else begin
                                    // fetch the byte that becomes the new end
                                    ram_re          = 1'b1;
                                    ram_raddr       = (req == REQ_POP_FRONT)
                                        ? ring_inc(front_reg)
                                        : ring_add(front_reg, count_m2[IDX_W-1:0]);
                                    popped_next     = popped;
                                    side_front_next = (req == REQ_POP_FRONT);
                                    state_next      = S_READ;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (side_front_reg) begin
                    front_val_next = ram_rdata;
                end else begin
                    back_val_next = ram_rdata;
                end
                popped     = popped_reg;
                res_valid  = 1'b1;
                state_next = S_IDLE;
            end
            default: ;
        endcase

        res.popped_byte = popped;
        res.status      = status;
        res.front_byte  = (count_next == '0) ? '0 : front_val_next;
        res.back_byte   = (count_next == '0) ? '0 : back_val_next;
        res.occupancy   = OCC_W'(count_next);
        res.empty_flag  = (count_next == '0);
        res.full_flag   = (count_next == CNT_W'(DEPTH));
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("deque count above capacity");

    a_front_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        front_reg <= IDX_W'(DEPTH - 1))
        else $error("front index outside ring");

    a_read_then_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |=> (state_reg == S_READ) && res_valid)
        else $error("issued read not followed by a result");

    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("read and write in the same cycle");

    a_no_accept_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> !in_ready)
        else $error("request accepted while a read is outstanding");

endmodule

`default_nettype wire
